[rtl/core/bsp_pkg.sv]
// Shared types, constants and control store for the BLDC speed PI duty block.
// Used by bsp_seq, bsp_dp and bldc_speed_pi_duty_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bsp_pkg;

    localparam int PERIOD_W = 16;
    localparam int DEMAND_W = 10;
    localparam int DUTY_W   = 11;
    localparam int SPEED_W  = 22;
    localparam int TARGET_W = 12;
    localparam int ESUM_W   = 14;
    localparam int GAIN_W   = 16;
    localparam int PROD_W   = GAIN_W + SPEED_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int PI_SHIFT = 12;
    localparam int CORR_W   = ACC_W - PI_SHIFT;
    localparam int SDUTY_W  = CORR_W + 2;
    localparam int DIV_BITS = SPEED_W;
    localparam int DCNT_W   = $clog2(DIV_BITS);
    localparam int STEP_W   = 4;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    localparam logic [PERIOD_W-1:0] PERIOD_LIMIT = 16'd23000;
    localparam logic [ESUM_W-1:0]   INTEG_LIMIT  = 14'd9000;
    localparam logic [DUTY_W-1:0]   DUTY_MAX     = 11'd1250;
    localparam logic [DUTY_W-1:0]   DUTY_MIN     = 11'd100;
    localparam logic [SPEED_W-1:0]  RPM_CONST    = 22'd2343720;
    localparam logic [GAIN_W-1:0]   PROP_GAIN_RST  = 16'd1200;
    localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST = 16'd10;

    localparam logic REG_PROP_GAIN  = 1'b0;
    localparam logic REG_INTEG_GAIN = 1'b1;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_DONE,
        OP_AVG,
        OP_ERR,
        OP_ESUM,
        OP_MUL_P,
        OP_MUL_I,
        OP_ADD,
        OP_DUTY,
        OP_CLAMP,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_ITEM,
        COND_LONG,
        COND_ZERO,
        COND_DIV_MORE,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        t_op op;
    } t_ctrl;

    typedef struct packed {
        logic item_avail;
        logic long_period;
        logic zero_period;
        logic div_more;
        logic out_busy;
    } t_flags;

    function automatic t_uword f_ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            4'd0:    w = '{OP_LOAD,     COND_NO_ITEM,  4'd0};
            4'd1:    w = '{OP_NOP,      COND_LONG,     4'd0};
            4'd2:    w = '{OP_NOP,      COND_ZERO,     4'd6};
            4'd3:    w = '{OP_DIV_INIT, COND_NONE,     4'd0};
            4'd4:    w = '{OP_DIV_STEP, COND_DIV_MORE, 4'd4};
            4'd5:    w = '{OP_DIV_DONE, COND_NONE,     4'd0};
            4'd6:    w = '{OP_AVG,      COND_NONE,     4'd0};
            4'd7:    w = '{OP_ERR,      COND_NONE,     4'd0};
            4'd8:    w = '{OP_ESUM,     COND_NONE,     4'd0};
            4'd9:    w = '{OP_MUL_P,    COND_NONE,     4'd0};
            4'd10:   w = '{OP_MUL_I,    COND_NONE,     4'd0};
            4'd11:   w = '{OP_ADD,      COND_NONE,     4'd0};
            4'd12:   w = '{OP_DUTY,     COND_NONE,     4'd0};
            4'd13:   w = '{OP_CLAMP,    COND_NONE,     4'd0};
            4'd14:   w = '{OP_OUT,      COND_OUT_BUSY, 4'd14};
            default: w = '{OP_NOP,      COND_ALWAYS,   4'd0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/core/bldc_speed_pi_duty_top.sv]
// BLDC speed PI duty controller, top level: stream ports, gain write port.
// Instantiates bsp_seq and bsp_dp; depends on bsp_pkg.
//
// Each input item holds one revolution period and the pot demand. Periods above
// 23000 are dropped with no result; a zero period reuses the last speed. Every
// other item gives one result: clamped duty, averaged speed, below-target flag.
// The gain port is always ready. Gain writes are to be made only while no item is
// in flight; the block itself does not enforce it. A microcode program of 16
// steps runs each item: one step accepts it, then a restoring divider forms the
// 22-bit speed, one bit per cycle; a single shared multiplier forms both PI
// products. The next item is taken only after the previous one has passed the
// output step or been dropped.
// The result sits in an output register: a stalled receiver holds it, and the
// block finishes the next item and then waits on the output step until it drains.
// Reset (synchronous, active low) sets the gains to 1200 and 10, clears the speed
// and integral state and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module bldc_speed_pi_duty_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // [15:0] rev_period, [25:16] demand, [31:26] zero
    input  wire logic [bsp_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // [10:0] duty_cycle, [32:11] avg_speed, [39:33] zero
    output logic [bsp_pkg::OUT_TDATA_W-1:0]          o_m_axis_tdata,
    // [0] below_target
    output logic                                     o_m_axis_tuser,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic                                i_cfg_index,
    input  wire logic [bsp_pkg::GAIN_W-1:0]          i_cfg_data
);

    bsp_pkg::t_ctrl                w_ctrl;
    bsp_pkg::t_flags               w_flags;
    logic [bsp_pkg::DUTY_W-1:0]    w_duty;
    logic [bsp_pkg::SPEED_W-1:0]   w_speed;
    logic                          w_cfg_we;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    bsp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    bsp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .o_flags     (w_flags),
        .i_cfg_valid (w_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_axis_tvalid),
        .o_s_tready  (o_s_axis_tready),
        .i_period    (i_s_axis_tdata[bsp_pkg::PERIOD_W-1:0]),
        .i_demand    (i_s_axis_tdata[bsp_pkg::PERIOD_W+bsp_pkg::DEMAND_W-1:bsp_pkg::PERIOD_W]),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_duty      (w_duty),
        .o_avg_speed (w_speed),
        .o_below     (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {
        (bsp_pkg::OUT_TDATA_W - bsp_pkg::DUTY_W - bsp_pkg::SPEED_W)'(0),
        w_speed,
        w_duty
    };

endmodule

`default_nettype wire

[rtl/core/bsp_seq.sv]
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on bsp_pkg for the control word, condition codes and flags.
`timescale 1ns / 1ps
`default_nettype none

module bsp_seq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire bsp_pkg::t_flags i_flags,
    output bsp_pkg::t_ctrl      o_ctrl
);

    logic [bsp_pkg::STEP_W-1:0] r_step;
    logic [bsp_pkg::STEP_W-1:0] n_step;
    bsp_pkg::t_uword            w_uword;
    logic                       w_take;

    assign w_uword = bsp_pkg::f_ucode(r_step);

    always_comb begin
        case (w_uword.cond)
            bsp_pkg::COND_NONE:     w_take = 1'b0;
            bsp_pkg::COND_ALWAYS:   w_take = 1'b1;
            bsp_pkg::COND_NO_ITEM:  w_take = !i_flags.item_avail;
            bsp_pkg::COND_LONG:     w_take = i_flags.long_period;
            bsp_pkg::COND_ZERO:     w_take = i_flags.zero_period;
            bsp_pkg::COND_DIV_MORE: w_take = i_flags.div_more;
            bsp_pkg::COND_OUT_BUSY: w_take = i_flags.out_busy;
            default:                w_take = 1'b1;
        endcase
        n_step = w_take ? w_uword.target : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl.op = w_uword.op;

endmodule

`default_nettype wire

[rtl/core/bsp_dp.sv]
// Datapath: gain registers, serial divider, shared multiplier, PI state and output stage.
// Driven by the op from bsp_seq; depends on bsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsp_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire bsp_pkg::t_ctrl                  i_ctrl,
    output bsp_pkg::t_flags                      o_flags,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_index,
    input  wire logic [bsp_pkg::GAIN_W-1:0]      i_cfg_data,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [bsp_pkg::PERIOD_W-1:0]    i_period,
    input  wire logic [bsp_pkg::DEMAND_W-1:0]    i_demand,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [bsp_pkg::DUTY_W-1:0]           o_duty,
    output logic [bsp_pkg::SPEED_W-1:0]          o_avg_speed,
    output logic                                 o_below
);

    logic [bsp_pkg::GAIN_W-1:0]   r_prop_gain;
    logic [bsp_pkg::GAIN_W-1:0]   r_integ_gain;
    logic [bsp_pkg::PERIOD_W-1:0] r_period;
    logic [bsp_pkg::DEMAND_W-1:0] r_dem;
    logic [bsp_pkg::PERIOD_W-1:0] r_rem;
    logic [bsp_pkg::SPEED_W-1:0]  r_quo;
    logic [bsp_pkg::DCNT_W-1:0]   r_cnt;
    logic [bsp_pkg::SPEED_W-1:0]  r_last;
    logic [bsp_pkg::SPEED_W-1:0]  r_run;
    logic [bsp_pkg::SPEED_W-1:0]  r_err;
    logic                         r_below;
    logic [bsp_pkg::ESUM_W-1:0]   r_esum;
    logic [bsp_pkg::PROD_W-1:0]   r_prod;
    logic [bsp_pkg::ACC_W-1:0]    r_acc;
    logic [bsp_pkg::SDUTY_W-1:0]  r_duty;
    logic                         r_m_valid;
    logic [bsp_pkg::DUTY_W-1:0]   r_m_duty;
    logic [bsp_pkg::SPEED_W-1:0]  r_m_speed;
    logic                         r_m_below;

    logic                         w_accept;
    logic                         w_out_free;
    logic [bsp_pkg::PERIOD_W:0]   w_rem_sh;
    logic [bsp_pkg::PERIOD_W:0]   w_rem_diff;
    logic [bsp_pkg::SPEED_W:0]    w_avg_sum;
    logic [bsp_pkg::SPEED_W-1:0]  w_target;
    logic [bsp_pkg::SPEED_W:0]    w_esum_sum;
    logic [bsp_pkg::GAIN_W-1:0]   w_mul_a;
    logic [bsp_pkg::SPEED_W-1:0]  w_mul_b;
    logic [bsp_pkg::PROD_W-1:0]   w_mul_p;
    logic [bsp_pkg::SDUTY_W-1:0]  w_dem_x;
    logic [bsp_pkg::SDUTY_W-1:0]  w_corr_x;
    logic                         w_duty_low;
    logic                         w_duty_high;

    assign o_s_tready = (i_ctrl.op == bsp_pkg::OP_LOAD);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_valid || i_m_tready;

    assign o_flags.item_avail  = i_s_tvalid;
    assign o_flags.long_period = (r_period > bsp_pkg::PERIOD_LIMIT);
    assign o_flags.zero_period = (r_period == '0);
    assign o_flags.div_more    = (r_cnt != '0);
    assign o_flags.out_busy    = !w_out_free;

    assign w_rem_sh   = {r_rem, r_quo[bsp_pkg::SPEED_W-1]};
    assign w_rem_diff = w_rem_sh - {1'b0, r_period};

    assign w_avg_sum  = {1'b0, r_run} + {1'b0, r_last};
    assign w_target   = bsp_pkg::SPEED_W'({r_dem, 1'b0}) + bsp_pkg::SPEED_W'(r_dem);
    assign w_esum_sum = (bsp_pkg::SPEED_W+1)'(r_esum) + {1'b0, r_err};

    assign w_mul_a = (i_ctrl.op == bsp_pkg::OP_MUL_I) ? r_integ_gain : r_prop_gain;
    assign w_mul_b = (i_ctrl.op == bsp_pkg::OP_MUL_I) ? bsp_pkg::SPEED_W'(r_esum) : r_err;
    assign w_mul_p = bsp_pkg::PROD_W'(w_mul_a) * bsp_pkg::PROD_W'(w_mul_b);

    assign w_dem_x  = bsp_pkg::SDUTY_W'(r_dem);
    assign w_corr_x = bsp_pkg::SDUTY_W'(r_acc[bsp_pkg::ACC_W-1:bsp_pkg::PI_SHIFT]);

    assign w_duty_low  = r_duty[bsp_pkg::SDUTY_W-1] ||
                         (r_duty < bsp_pkg::SDUTY_W'(bsp_pkg::DUTY_MIN));
    assign w_duty_high = !r_duty[bsp_pkg::SDUTY_W-1] &&
                         (r_duty > bsp_pkg::SDUTY_W'(bsp_pkg::DUTY_MAX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= bsp_pkg::PROP_GAIN_RST;
            r_integ_gain <= bsp_pkg::INTEG_GAIN_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == bsp_pkg::REG_PROP_GAIN) begin
                r_prop_gain <= i_cfg_data;
            end else begin
                r_integ_gain <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_run  <= '0;
            r_esum <= '0;
        end else begin
            case (i_ctrl.op)
                bsp_pkg::OP_DIV_DONE: r_last <= r_quo;
                bsp_pkg::OP_AVG:      r_run  <= w_avg_sum[bsp_pkg::SPEED_W:1];
                bsp_pkg::OP_ESUM: begin
                    if (w_esum_sum > (bsp_pkg::SPEED_W+1)'(bsp_pkg::INTEG_LIMIT)) begin
                        r_esum <= '0;
                    end else begin
                        r_esum <= w_esum_sum[bsp_pkg::ESUM_W-1:0];
                    end
                end
                bsp_pkg::OP_CLAMP: begin
                    if (!w_duty_low && w_duty_high) begin
                        r_esum <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_period <= i_period;
            r_dem    <= i_demand;
        end
        case (i_ctrl.op)
            bsp_pkg::OP_DIV_INIT: begin
                r_rem <= '0;
                r_quo <= bsp_pkg::RPM_CONST;
                r_cnt <= bsp_pkg::DCNT_W'(bsp_pkg::DIV_BITS - 1);
            end
            bsp_pkg::OP_DIV_STEP: begin
                if (!w_rem_diff[bsp_pkg::PERIOD_W]) begin
                    r_rem <= w_rem_diff[bsp_pkg::PERIOD_W-1:0];
                end else begin
                    r_rem <= w_rem_sh[bsp_pkg::PERIOD_W-1:0];
                end
                r_quo <= {r_quo[bsp_pkg::SPEED_W-2:0], !w_rem_diff[bsp_pkg::PERIOD_W]};
                r_cnt <= r_cnt - 1'b1;
            end
            bsp_pkg::OP_ERR: begin
                if (r_run > w_target) begin
                    r_err   <= r_run - w_target;
                    r_below <= 1'b0;
                end else begin
                    r_err   <= w_target - r_run;
                    r_below <= 1'b1;
                end
            end
            bsp_pkg::OP_MUL_P: r_prod <= w_mul_p;
            bsp_pkg::OP_MUL_I: begin
                r_acc  <= {1'b0, r_prod};
                r_prod <= w_mul_p;
            end
            bsp_pkg::OP_ADD: r_acc <= r_acc + {1'b0, r_prod};
            bsp_pkg::OP_DUTY: r_duty <= r_below ? w_dem_x + w_corr_x : w_dem_x - w_corr_x;
            bsp_pkg::OP_CLAMP: begin
                if (w_duty_low) begin
                    r_duty <= bsp_pkg::SDUTY_W'(bsp_pkg::DUTY_MIN);
                end else if (w_duty_high) begin
                    r_duty <= bsp_pkg::SDUTY_W'(bsp_pkg::DUTY_MAX);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_ctrl.op == bsp_pkg::OP_OUT && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == bsp_pkg::OP_OUT && w_out_free) begin
            r_m_duty  <= r_duty[bsp_pkg::DUTY_W-1:0];
            r_m_speed <= r_run;
            r_m_below <= r_below;
        end
    end

    assign o_m_tvalid  = r_m_valid;
    assign o_duty      = r_m_duty;
    assign o_avg_speed = r_m_speed;
    assign o_below     = r_m_below;

endmodule

`default_nettype wire

[verif/tb_bldc_speed_pi_duty_top.sv]
// Self-checking testbench for bldc_speed_pi_duty_top: stream items in, duty results out.
// Predicts each result from its own speed, integral and gain state; depends on bsp_pkg.
`timescale 1ns / 1ps

module tb_bldc_speed_pi_duty_top;
    import bsp_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 48;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 80;

    typedef struct {
        logic [DUTY_W-1:0]  duty;
        logic [SPEED_W-1:0] rpm;
        logic               below;
    } pi_result_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_data = '0;
    logic                   m_ready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_index = REG_PROP_GAIN;
    logic [GAIN_W-1:0]      cfg_data = '0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tuser;
    logic                   o_cfg_ready;

    // speed, integral and gain state of the controller
    logic [SPEED_W-1:0] last_rpm = '0;
    logic [SPEED_W-1:0] avg_rpm = '0;
    logic [23:0]        err_integral = '0;
    logic [GAIN_W-1:0]  kp = PROP_GAIN_RST;
    logic [GAIN_W-1:0]  ki = INTEG_GAIN_RST;

    pi_result_t duty_expect_q[$];

    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    logic hold_tog = 1'b0;
    int n_errors = 0;
    int n_items = 0;
    int n_dropped = 0;
    int n_zero = 0;
    int n_results = 0;
    int n_gain_sets = 0;
    int n_upper = 0;
    int n_lower = 0;
    int n_integ_resets = 0;

    bldc_speed_pi_duty_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit pi_duty_predict(input logic [PERIOD_W-1:0] period,
                                           input logic [DEMAND_W-1:0] demand,
                                           output pi_result_t r);
        longint unsigned corr;
        longint          duty;
        int unsigned     target;
        int unsigned     err;
        bit              below;
        r = '{default: '0};
        if (period > PERIOD_LIMIT)
            return 1'b0;
        if (period != 0)
            last_rpm = RPM_CONST / period;
        avg_rpm = SPEED_W'((32'(avg_rpm) + 32'(last_rpm)) >> 1);
        target = 3 * 32'(demand);
        below = (32'(avg_rpm) <= target);
        err = below ? target - 32'(avg_rpm) : 32'(avg_rpm) - target;
        err_integral = err_integral + 24'(err);
        if (err_integral > 24'(INTEG_LIMIT)) begin
            err_integral = '0;
            n_integ_resets++;
        end
        corr = (64'(kp) * 64'(err) + 64'(ki) * 64'(err_integral)) >> PI_SHIFT;
        duty = below ? longint'(demand) + longint'(corr) : longint'(demand) - longint'(corr);
        if (duty < longint'(DUTY_MIN)) begin
            duty = longint'(DUTY_MIN);
            n_lower++;
        end
        if (duty > longint'(DUTY_MAX)) begin
            duty = longint'(DUTY_MAX);
            err_integral = '0;
            n_upper++;
        end
        r.duty  = duty[DUTY_W-1:0];
        r.rpm   = avg_rpm;
        r.below = below;
        return 1'b1;
    endfunction

    task automatic send_item(input logic [PERIOD_W-1:0] period,
                             input logic [DEMAND_W-1:0] demand, output bit produced);
        pi_result_t r;
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= IN_TDATA_W'({demand, period});
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_items++;
        if (period == 0)
            n_zero++;
        produced = pi_duty_predict(period, demand, r);
        if (produced)
            duty_expect_q.push_back(r);
        else
            n_dropped++;
    endtask

    task automatic send(input logic [PERIOD_W-1:0] period, input logic [DEMAND_W-1:0] demand);
        bit produced;
        send_item(period, demand, produced);
    endtask

    // hold the input low until every pending result has come back
    task automatic wait_results();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (duty_expect_q.size() != 0);
    endtask

    // drain results, then cover a dropped item still in flight
    task automatic wait_quiet();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_gains(input logic [GAIN_W-1:0] p_gain, input logic [GAIN_W-1:0] i_gain);
        cfg_valid <= 1'b1;
        cfg_index <= REG_PROP_GAIN;
        cfg_data  <= p_gain;
        do @(posedge i_clk); while (!o_cfg_ready);
        kp = p_gain;
        cfg_index <= REG_INTEG_GAIN;
        cfg_data  <= i_gain;
        do @(posedge i_clk); while (!o_cfg_ready);
        ki = i_gain;
        cfg_valid <= 1'b0;
        n_gain_sets++;
    endtask

    task automatic test_directed_defaults();
        send(16'd0, 10'd0);
        send(16'd0, 10'd1023);
        send(16'd1, 10'd0);
        send(16'd23000, 10'd512);
        send(16'd23001, 10'd512);
        send(16'hFFFF, 10'd1023);
        send(16'hAAAA, 10'h2AA);
        send(16'h5555, 10'h155);
        send(16'h2AAA, 10'h2AA);
        send(16'd0, 10'd700);
        repeat (5) send(16'd781, 10'd0);
        repeat (3) send(16'd1953, 10'd400);
        wait_quiet();
    endtask

    task automatic test_gain_extremes();
        set_gains('0, '0);
        send(16'd2343, 10'd300);
        send(16'd0, 10'd1023);
        wait_quiet();
        set_gains('1, '1);
        send(16'd1, 10'd1023);
        send(16'd23000, 10'd0);
        send(16'd0, 10'd512);
        wait_quiet();
    endtask

    task automatic test_backpressure();
        tx_steady = 1'b1;
        hold_tog <= ~hold_tog;
        repeat (10) send(16'($urandom_range(1, 23000)), 10'($urandom_range(0, 1023)));
        tx_steady = 1'b0;
        wait_results();
        repeat (6) send(16'($urandom_range(1, 23000)), 10'($urandom_range(0, 1023)));
        wait_quiet();
    endtask

    task automatic send_random_item(output bit produced);
        logic [PERIOD_W-1:0] period;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            period = '0;
        else if (sel < 20)
            period = 16'($urandom_range(23001, 65535));
        else if (sel < 30)
            period = 16'($urandom_range(1, 300));
        else
            period = 16'($urandom_range(301, 23000));
        send_item(period, 10'($urandom_range(0, 1023)), produced);
    endtask

    task automatic test_random();
        int produced;
        bit res;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_gains(16'($urandom_range(200, 4000)), 16'($urandom_range(0, 200)));
                1: set_gains('0, 16'($urandom_range(0, 65535)));
                2: set_gains(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                3: set_gains('1, '0);
                default: set_gains(PROP_GAIN_RST, INTEG_GAIN_RST);
            endcase
            tx_steady = (ph == 2);
            rx_steady = (ph == 2);
            produced = 0;
            while (produced < PHASE_ITEMS) begin
                send_random_item(res);
                if (res) begin
                    produced++;
                    if (produced % 25 == 0)
                        wait_results();
                end
            end
            tx_steady = 1'b0;
            rx_steady = 1'b0;
            wait_quiet();
        end
    endtask

    // result check and receiver stalls
    initial begin
        pi_result_t exp_r;
        int stall_left;
        logic hold_seen;
        stall_left = 0;
        hold_seen = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && m_ready) begin
                n_results++;
                if (duty_expect_q.size() == 0) begin
                    $error("duty result with no item pending: tdata %h", o_m_axis_tdata);
                    n_errors++;
                end else begin
                    exp_r = duty_expect_q.pop_front();
                    if (o_m_axis_tdata[DUTY_W-1:0] !== exp_r.duty) begin
                        $error("duty_cycle expected %0d got %0d", exp_r.duty,
                               o_m_axis_tdata[DUTY_W-1:0]);
                        n_errors++;
                    end
                    if (o_m_axis_tdata[DUTY_W+SPEED_W-1:DUTY_W] !== exp_r.rpm) begin
                        $error("avg_speed expected %0d got %0d", exp_r.rpm,
                               o_m_axis_tdata[DUTY_W+SPEED_W-1:DUTY_W]);
                        n_errors++;
                    end
                    if (o_m_axis_tuser !== exp_r.below) begin
                        $error("below_target expected %0d got %0d", exp_r.below,
                               o_m_axis_tuser);
                        n_errors++;
                    end
                end
                if (!rx_steady)
                    stall_left = $urandom_range(0, 4);
            end
            if (hold_tog !== hold_seen) begin
                hold_seen = hold_tog;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready) ||
                (cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("bldc_speed_pi_duty_top test failed");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_defaults();
        test_gain_extremes();
        test_backpressure();
        test_random();
        $display("run: %0d items in, %0d dropped long periods, %0d zero periods, %0d results",
                 n_items, n_dropped, n_zero, n_results);
        $display("run: %0d gain settings, %0d upper and %0d lower clamps, %0d integral resets",
                 n_gain_sets, n_upper, n_lower, n_integ_resets);
        if (n_errors == 0 && duty_expect_q.size() == 0) begin
            $display("bldc_speed_pi_duty_top test passed");
        end else begin
            $display("bldc_speed_pi_duty_top test failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/bsp_pkg.sv
rtl/core/bsp_seq.sv
rtl/core/bsp_dp.sv
rtl/core/bldc_speed_pi_duty_top.sv
verif/tb_bldc_speed_pi_duty_top.sv
